// File: hdl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPLIES(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error(msg);

`endif

// File: hdl/sadc_pkg.sv
package sadc_pkg;

  // fixed field widths
  localparam int COMMAND_BITS    = 8;
  localparam int RESULT_BITS_DEF = 12;
  localparam int VALUE_W         = 12;
  localparam int WAIT_W          = 8;
  localparam int OP_W            = 2;

  localparam logic [WAIT_W-1:0] WAIT_RESET = 8'd6;

  // operation codes
  localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
  localparam logic [OP_W-1:0] OP_SINGLE = 2'd1;
  localparam logic [OP_W-1:0] OP_PEAK   = 2'd2;

  // one input tick
  typedef struct packed {
    logic [OP_W-1:0]         operation;
    logic [COMMAND_BITS-1:0] command;
    logic                    dout;
  } sadc_in_t;

  // one output tick
  typedef struct packed {
    logic               sclk;
    logic               cs_n;
    logic               din;
    logic               busy_res;
    logic               result_valid;
    logic [VALUE_W-1:0] result_value;
    logic               result_is_peak;
  } sadc_out_t;

endpackage

// File: hdl/sadc_core.sv
module sadc_core #(
  parameter int RESULT_BITS = sadc_pkg::RESULT_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  sadc_pkg::sadc_in_t          tick,
  input  logic                        cfg_write,
  input  logic [sadc_pkg::WAIT_W-1:0] cfg_data,
  output sadc_pkg::sadc_out_t         report
);
  import sadc_pkg::*;

  localparam int BC_SPAN   = (RESULT_BITS > COMMAND_BITS) ? RESULT_BITS : COMMAND_BITS;
  localparam int BC_W      = $clog2(BC_SPAN);
  localparam int CMD_IDX_W = $clog2(COMMAND_BITS);
  localparam int EXT_W     = (RESULT_BITS > VALUE_W) ? RESULT_BITS : VALUE_W;

  typedef enum logic [6:0] {
    PH_IDLE     = 7'b0000001,
    PH_SELECT   = 7'b0000010,
    PH_CMD      = 7'b0000100,
    PH_WAIT     = 7'b0001000,
    PH_CLEAR    = 7'b0010000,
    PH_READ     = 7'b0100000,
    PH_DESELECT = 7'b1000000
  } phase_t;

  phase_t                  phase, phase_next, phase_cur;
  logic [WAIT_W-1:0]       wait_ticks;
  logic [BC_W-1:0]         bit_count, bit_count_next;
  logic [COMMAND_BITS-1:0] command_shift, command_shift_next;
  logic [RESULT_BITS-1:0]  receive_shift, receive_shift_next;
  logic [WAIT_W-1:0]       wait_count, wait_count_next, wait_dec;
  logic                    peak_mode, peak_mode_next;
  logic                    rising_stage, rising_stage_next;
  logic                    have_previous, have_previous_next;
  logic [RESULT_BITS-1:0]  previous_value, previous_value_next;
  logic                    clock_high, clock_high_next;
  logic                    start;
  logic [RESULT_BITS-1:0]  value_sel;
  logic [EXT_W-1:0]        value_ext;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      wait_ticks <= WAIT_RESET;
    end else if (cfg_write) begin
      wait_ticks <= cfg_data;
    end
  end

  assign start = (phase == PH_IDLE) &&
                 ((tick.operation == OP_SINGLE) || (tick.operation == OP_PEAK));
  assign wait_dec = wait_count - WAIT_W'(1);

  // one tick of the serial sequencer
  always_comb begin
    phase_next          = phase;
    bit_count_next      = bit_count;
    command_shift_next  = command_shift;
    receive_shift_next  = receive_shift;
    wait_count_next     = wait_count;
    peak_mode_next      = peak_mode;
    rising_stage_next   = rising_stage;
    have_previous_next  = have_previous;
    previous_value_next = previous_value;
    clock_high_next     = clock_high;
    value_sel           = '0;
    report              = '0;
    report.busy_res     = 1'b1;

    // start of a transaction only from idle
    if (start) begin
      command_shift_next  = tick.command;
      peak_mode_next      = (tick.operation == OP_PEAK);
      rising_stage_next   = 1'b0;
      have_previous_next  = 1'b0;
      previous_value_next = '0;
      phase_cur           = PH_SELECT;
    end else begin
      phase_cur = phase;
    end

    unique case (phase_cur)
      PH_SELECT: begin
        receive_shift_next = '0;
        bit_count_next     = BC_W'(COMMAND_BITS - 1);
        clock_high_next    = 1'b0;
        phase_next         = PH_CMD;
      end
      PH_CMD: begin
        report.din  = command_shift[bit_count[CMD_IDX_W-1:0]];
        report.sclk = clock_high;
        if (clock_high) begin
          clock_high_next = 1'b0;
          if (bit_count == '0) begin
            wait_count_next = wait_ticks;
            phase_next      = (wait_ticks == '0) ? PH_CLEAR : PH_WAIT;
          end else begin
            bit_count_next = bit_count - BC_W'(1);
          end
        end else begin
          clock_high_next = 1'b1;
        end
      end
      PH_WAIT: begin
        report.sclk     = 1'b1;
        wait_count_next = wait_dec;
        if (wait_dec == '0) begin
          phase_next = PH_CLEAR;
        end
      end
      PH_CLEAR: begin
        bit_count_next  = BC_W'(RESULT_BITS - 1);
        clock_high_next = 1'b1;
        phase_next      = PH_READ;
      end
      PH_READ: begin
        report.sclk = clock_high;
        if (clock_high) begin
          clock_high_next = 1'b0;
        end else begin
          clock_high_next    = 1'b1;
          receive_shift_next = {receive_shift[RESULT_BITS-2:0], tick.dout};
          if (bit_count == '0) begin
            phase_next = PH_DESELECT;
          end else begin
            bit_count_next = bit_count - BC_W'(1);
          end
        end
      end
      PH_DESELECT: begin
        report.cs_n = 1'b1;
        if (!peak_mode) begin
          report.result_valid = 1'b1;
          value_sel           = receive_shift;
          phase_next          = PH_IDLE;
        end else if (!have_previous) begin
          previous_value_next = receive_shift;
          have_previous_next  = 1'b1;
          phase_next          = PH_SELECT;
        end else if (!rising_stage) begin
          // falling stretch: wait for the first rise
          if (receive_shift > previous_value) begin
            rising_stage_next = 1'b1;
          end
          previous_value_next = receive_shift;
          phase_next          = PH_SELECT;
        end else if (receive_shift >= previous_value) begin
          previous_value_next = receive_shift;
          phase_next          = PH_SELECT;
        end else begin
          // first drop after the rise: report the peak
          report.result_valid   = 1'b1;
          report.result_is_peak = 1'b1;
          value_sel             = previous_value;
          phase_next            = PH_IDLE;
        end
      end
      default: begin
        phase_next      = PH_IDLE;
        report.cs_n     = 1'b1;
        report.busy_res = 1'b0;
      end
    endcase

    value_ext           = EXT_W'(value_sel);
    report.result_value = value_ext[VALUE_W-1:0];
  end

  // state update on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      bit_count      <= '0;
      command_shift  <= '0;
      receive_shift  <= '0;
      wait_count     <= '0;
      peak_mode      <= 1'b0;
      rising_stage   <= 1'b0;
      have_previous  <= 1'b0;
      previous_value <= '0;
      clock_high     <= 1'b0;
    end else if (accept) begin
      phase          <= phase_next;
      bit_count      <= bit_count_next;
      command_shift  <= command_shift_next;
      receive_shift  <= receive_shift_next;
      wait_count     <= wait_count_next;
      peak_mode      <= peak_mode_next;
      rising_stage   <= rising_stage_next;
      have_previous  <= have_previous_next;
      previous_value <= previous_value_next;
      clock_high     <= clock_high_next;
    end
  end

endmodule

// File: hdl/sadc_obuf.sv
module sadc_obuf (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  sadc_pkg::sadc_out_t data_in,
  output logic                full,
  input  logic                take_stall,
  output sadc_pkg::sadc_out_t data_out
);
  import sadc_pkg::*;

  sadc_out_t data;
  logic      full_next;

  // holds while stalled, refills in the cycle it drains
  always_comb begin
    if (load) begin
      full_next = 1'b1;
    end else if (full && take_stall) begin
      full_next = 1'b1;
    end else begin
      full_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else begin
      full <= full_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= data_in;
    end
  end

  assign data_out = data;

endmodule

// File: hdl/serial_adc_read_with_peak_search.sv
// channel  | valid        | stall        | payload
// ---------+--------------+--------------+----------------------
// tick     | tick_valid   | tick_stall   | tick   (sadc_in_t)
// report   | report_valid | report_stall | report (sadc_out_t)
// config   | cfg_write    | -            | cfg_data (wait_ticks)
//
// one tick transaction per clock while tick_stall is low; its report is ready in the cycle after acceptance
// the sequencer state and the output register are the only stages in the path
// reset (rst, synchronous) puts the sequencer idle with wait_ticks = 6
// tick_stall is high only while a report is held and report_stall is high
`include "assert_macros.svh"

module serial_adc_read_with_peak_search #(
  parameter int RESULT_BITS = sadc_pkg::RESULT_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        tick_valid,
  output logic                        tick_stall,
  input  sadc_pkg::sadc_in_t          tick,
  output logic                        report_valid,
  input  logic                        report_stall,
  output sadc_pkg::sadc_out_t         report,
  input  logic                        cfg_write,
  input  logic [sadc_pkg::WAIT_W-1:0] cfg_data
);
  import sadc_pkg::*;

  logic      accept;
  sadc_out_t step_out;

  assign tick_stall = report_valid && report_stall;
  assign accept     = tick_valid && !tick_stall;

  // sequencer state and per-tick logic
  sadc_core #(
    .RESULT_BITS(RESULT_BITS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .tick     (tick),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data),
    .report   (step_out)
  );

  // output register
  sadc_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .data_in   (step_out),
    .full      (report_valid),
    .take_stall(report_stall),
    .data_out  (report)
  );

  // checks
  `ASSERT_IMPLIES(a_report_deselect, clk, rst, report_valid && report.result_valid, report.busy_res && report.cs_n && !report.sclk, "report not on a deselect tick")
  `ASSERT_IMPLIES(a_din_selected, clk, rst, report_valid && report.din, !report.cs_n && report.busy_res, "din driven while deselected")
  `ASSERT_IMPLIES(a_peak_flag, clk, rst, report_valid && report.result_is_peak, report.result_valid, "peak flag without result")
  `ASSERT_IMPLIES(a_stall_full, clk, rst, tick_stall, report_valid, "input stalled with empty output register")
  `ASSERT_NEXT(a_accept_fills, clk, rst, accept, report_valid, "accepted transaction left no report")

endmodule
